FILE: rtl/assert_macros.svh
// Shared assertion macros for the polygon angle checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/pmia_pkg.sv
package pmia_pkg;

  localparam int COORD_BITS = 24;
  localparam int PRE_SHIFT  = (COORD_BITS > 29) ? COORD_BITS - 29 : 0;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int EDGE_W     = DIFF_W - PRE_SHIFT;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 32;
  localparam int MUL_STEPS  = 9;
  localparam logic [33:0] PI_Q30      = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic                         last_vertex;
  } vertex_t;

  typedef struct packed {
    logic [15:0] max_angle;
    logic        degenerate;
    logic        no_valid_angle;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL, S_ZERO, S_NORM, S_SQRT, S_DEN, S_SCALE,
    S_DIV, S_CSQ, S_CORDIC, S_ANGLE, S_NEXT, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_MID, PH_END1, PH_END2
  } phase_t;

  typedef enum logic [1:0] {
    ROOT_U, ROOT_V, ROOT_S
  } root_t;

  // Truncated Q30 arctangent of 2^-k.
  function automatic logic [30:0] atan_q30(input logic [4:0] k);
    logic [30:0] r;
    case (k)
      5'd0:  r = 31'd843314856;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043836;
      5'd3:  r = 31'd133525158;
      5'd4:  r = 31'd67021686;
      5'd5:  r = 31'd33543515;
      5'd6:  r = 31'd16775850;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194282;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048575;
      5'd11: r = 31'd524287;
      5'd12: r = 31'd262143;
      5'd13: r = 31'd131071;
      5'd14: r = 31'd65535;
      5'd15: r = 31'd32767;
      5'd16: r = 31'd16383;
      5'd17: r = 31'd8191;
      5'd18: r = 31'd4095;
      5'd19: r = 31'd2047;
      5'd20: r = 31'd1023;
      5'd21: r = 31'd511;
      5'd22: r = 31'd255;
      5'd23: r = 31'd127;
      5'd24: r = 31'd63;
      5'd25: r = 31'd31;
      5'd26: r = 31'd15;
      5'd27: r = 31'd7;
      5'd28: r = 31'd3;
      5'd29: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/polygon_max_interior_angle.sv
// A vertex that closes a corner holds the input until its corner is done: multiply, then,
// unless an edge has zero length, normalize, three 32-step roots, a 30-step divide (skipped
// on a saturated cosine) and 30 CORDIC steps, all on one shared unit.
// A last vertex adds two wrap-around corners; for two or fewer vertices it goes straight to
// the finish state, else after its corners; the result then waits on any result_stall.
// Throughput: one vertex per corner time. Reset (rst, synchronous, active high) clears state.
module polygon_max_interior_angle #(
  parameter int ANGLE_FRAC_BITS = 14,
  parameter int COUNT_BITS      = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pmia_pkg::vertex_t  vertex,
  input  logic               vertex_valid,
  output logic               vertex_stall,
  output pmia_pkg::result_t  result,
  output logic               result_valid,
  input  logic               result_stall
);

  localparam int ANG_W  = ANGLE_FRAC_BITS + 2;
  localparam int EW     = pmia_pkg::EDGE_W;
  localparam int CW     = pmia_pkg::COORD_BITS;
  localparam int DIFF_W = pmia_pkg::DIFF_W;

  pmia_pkg::state_t state, state_next;
  pmia_pkg::phase_t phase;
  pmia_pkg::root_t  root_sel;

  logic signed [CW-1:0] win [4][3];
  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic signed [CW-1:0] pc [3];
  logic signed [EW-1:0] eu [3];
  logic signed [EW-1:0] ev [3];

  logic [COUNT_BITS-1:0] vertex_count;
  logic                  last_flag;
  logic [ANG_W-1:0]      running_max;
  logic                  any_valid;
  logic [4:0]            step;

  logic [63:0]        uu, vv;
  logic signed [63:0] dot;
  logic [4:0]         ea, eb;
  logic [63:0]        sq_n, sq_res;
  logic [30:0]        su, sv;
  logic [63:0]        den, num;
  logic [30:0]        cq;
  logic signed [33:0] cx, cy, cz;

  logic accept, out_load;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  // Square root step values.
  logic [63:0] sq_bit, sq_try, sq_n_next, sq_res_next;
  logic        sq_take;
  // Scale and angle helpers.
  logic [5:0]   esum;
  logic [63:0]  mag;
  logic [127:0] scaled;
  logic [63:0]  num2;
  logic signed [34:0] zc, za, zr;
  logic [ANG_W-1:0]   ang;
  logic [1:0]   lane;
  logic [31:0]  rm_ext;

  assign accept = vertex_valid && !vertex_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pmia_pkg::S_IDLE: begin
        if (accept) begin
          if (vertex_count >= COUNT_BITS'(2)) state_next = pmia_pkg::S_DIFF;
          else if (vertex.last_vertex) state_next = pmia_pkg::S_FINISH;
        end
      end
      pmia_pkg::S_DIFF: state_next = pmia_pkg::S_MUL;
      pmia_pkg::S_MUL: begin
        if (step == 5'(pmia_pkg::MUL_STEPS - 1)) state_next = pmia_pkg::S_ZERO;
      end
      pmia_pkg::S_ZERO: begin
        if (uu == 64'd0 || vv == 64'd0) state_next = pmia_pkg::S_NEXT;
        else state_next = pmia_pkg::S_NORM;
      end
      pmia_pkg::S_NORM: begin
        if (uu[63:60] != 4'd0 && vv[63:60] != 4'd0) state_next = pmia_pkg::S_SQRT;
      end
      pmia_pkg::S_SQRT: begin
        if (step == 5'd0) begin
          case (root_sel)
            pmia_pkg::ROOT_U: state_next = pmia_pkg::S_SQRT;
            pmia_pkg::ROOT_V: state_next = pmia_pkg::S_DEN;
            default:          state_next = pmia_pkg::S_CORDIC;
          endcase
        end
      end
      pmia_pkg::S_DEN: state_next = pmia_pkg::S_SCALE;
      pmia_pkg::S_SCALE: begin
        if ((|scaled[127:64]) || scaled[63:0] >= den) state_next = pmia_pkg::S_CSQ;
        else state_next = pmia_pkg::S_DIV;
      end
      pmia_pkg::S_DIV: begin
        if (step == 5'(pmia_pkg::DIV_STEPS - 1)) state_next = pmia_pkg::S_CSQ;
      end
      pmia_pkg::S_CSQ: state_next = pmia_pkg::S_SQRT;
      pmia_pkg::S_CORDIC: begin
        if (step == 5'(pmia_pkg::CORDIC_STEPS - 1)) state_next = pmia_pkg::S_ANGLE;
      end
      pmia_pkg::S_ANGLE: state_next = pmia_pkg::S_NEXT;
      pmia_pkg::S_NEXT: begin
        case (phase)
          pmia_pkg::PH_MID:  state_next = last_flag ? pmia_pkg::S_DIFF : pmia_pkg::S_IDLE;
          pmia_pkg::PH_END1: state_next = pmia_pkg::S_DIFF;
          default:           state_next = pmia_pkg::S_FINISH;
        endcase
      end
      pmia_pkg::S_FINISH: begin
        if (!result_valid || !result_stall) state_next = pmia_pkg::S_IDLE;
      end
      default: state_next = pmia_pkg::S_IDLE;
    endcase
  end

  // Outputs and shared multiplier operands.
  always_comb begin
    vertex_stall = (state != pmia_pkg::S_IDLE);
    out_load     = (state == pmia_pkg::S_FINISH) && (!result_valid || !result_stall);
    lane  = 2'd0;
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (state)
      pmia_pkg::S_MUL: begin
        case (step)
          5'd0, 5'd3, 5'd6: lane = 2'd0;
          5'd1, 5'd4, 5'd7: lane = 2'd1;
          default:          lane = 2'd2;
        endcase
        if (step < 5'd3) begin
          mul_a = 32'(eu[lane]);
          mul_b = 32'(eu[lane]);
        end else if (step < 5'd6) begin
          mul_a = 32'(ev[lane]);
          mul_b = 32'(ev[lane]);
        end else begin
          mul_a = 32'(eu[lane]);
          mul_b = 32'(ev[lane]);
        end
      end
      pmia_pkg::S_DEN: begin
        mul_a = signed'({1'b0, su});
        mul_b = signed'({1'b0, sv});
      end
      pmia_pkg::S_CSQ: begin
        mul_a = signed'({1'b0, cq});
        mul_b = signed'({1'b0, cq});
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Square root, scale and angle arithmetic.
  always_comb begin
    sq_bit      = 64'd1 << {step, 1'b0};
    sq_try      = sq_res + sq_bit;
    sq_take     = (sq_n >= sq_try);
    sq_n_next   = sq_take ? sq_n - sq_try : sq_n;
    sq_res_next = sq_take ? (sq_res >> 1) + sq_bit : (sq_res >> 1);
    esum   = {1'b0, ea} + {1'b0, eb};
    mag    = dot[63] ? 64'(-dot) : 64'(dot);
    scaled = {64'd0, mag} << esum;
    num2   = num << 1;
    if (cz < 34'sd0) zc = 35'sd0;
    else if (cz > signed'({1'b0, pmia_pkg::HALF_PI_Q30})) zc = signed'({1'b0, pmia_pkg::HALF_PI_Q30});
    else zc = 35'(cz);
    za  = dot[63] ? signed'({1'b0, pmia_pkg::PI_Q30}) - zc : zc;
    zr  = za + (35'sd1 <<< (29 - ANGLE_FRAC_BITS));
    ang = zr[30-ANGLE_FRAC_BITS +: ANG_W];
    rm_ext = 32'(running_max);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pmia_pkg::S_IDLE;
      vertex_count <= '0;
      running_max  <= '0;
      any_valid    <= 1'b0;
      result_valid <= 1'b0;
      step         <= '0;
      phase        <= pmia_pkg::PH_MID;
      root_sel     <= pmia_pkg::ROOT_U;
      last_flag    <= 1'b0;
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 3; k++) win[i][k] <= '0;
    end else begin
      state <= state_next;
      if (out_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      case (state)
        pmia_pkg::S_IDLE: begin
          if (accept) begin
            last_flag <= vertex.last_vertex;
            phase     <= pmia_pkg::PH_MID;
            if (vertex_count != {COUNT_BITS{1'b1}}) vertex_count <= vertex_count + COUNT_BITS'(1);
            if (vertex_count == '0) begin
              win[0][0] <= vertex.vertex_x; win[0][1] <= vertex.vertex_y;
              win[0][2] <= vertex.vertex_z;
            end
            if (vertex_count == COUNT_BITS'(1)) begin
              win[1][0] <= vertex.vertex_x; win[1][1] <= vertex.vertex_y;
              win[1][2] <= vertex.vertex_z;
            end
            for (int k = 0; k < 3; k++) win[2][k] <= win[3][k];
            win[3][0] <= vertex.vertex_x; win[3][1] <= vertex.vertex_y;
            win[3][2] <= vertex.vertex_z;
          end
        end
        pmia_pkg::S_DIFF: step <= '0;
        pmia_pkg::S_MUL: step <= step + 5'd1;
        pmia_pkg::S_NORM: begin
          step     <= 5'(pmia_pkg::SQRT_STEPS - 1);
          root_sel <= pmia_pkg::ROOT_U;
        end
        pmia_pkg::S_SQRT: begin
          step <= step - 5'd1;
          if (step == 5'd0) begin
            step <= 5'(pmia_pkg::SQRT_STEPS - 1);
            if (root_sel == pmia_pkg::ROOT_U) root_sel <= pmia_pkg::ROOT_V;
            else step <= '0;
          end
        end
        pmia_pkg::S_SCALE: step <= '0;
        pmia_pkg::S_DIV: step <= step + 5'd1;
        pmia_pkg::S_CSQ: begin
          step     <= 5'(pmia_pkg::SQRT_STEPS - 1);
          root_sel <= pmia_pkg::ROOT_S;
        end
        pmia_pkg::S_CORDIC: step <= step + 5'd1;
        pmia_pkg::S_ANGLE: begin
          if (!any_valid || ang > running_max) running_max <= ang;
          any_valid <= 1'b1;
        end
        pmia_pkg::S_NEXT: begin
          if (phase == pmia_pkg::PH_MID) phase <= pmia_pkg::PH_END1;
          else if (phase == pmia_pkg::PH_END1) phase <= pmia_pkg::PH_END2;
        end
        pmia_pkg::S_FINISH: begin
          if (out_load) begin
            vertex_count <= '0;
            running_max  <= '0;
            any_valid    <= 1'b0;
          end
        end
        default: step <= step;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      pmia_pkg::S_IDLE: begin
        for (int k = 0; k < 3; k++) begin
          pa[k] <= win[2][k];
          pb[k] <= win[3][k];
        end
        pc[0] <= vertex.vertex_x; pc[1] <= vertex.vertex_y; pc[2] <= vertex.vertex_z;
      end
      pmia_pkg::S_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          eu[k] <= EW'((DIFF_W'(pc[k]) - DIFF_W'(pb[k])) >>> pmia_pkg::PRE_SHIFT);
          ev[k] <= EW'((DIFF_W'(pa[k]) - DIFF_W'(pb[k])) >>> pmia_pkg::PRE_SHIFT);
        end
        uu  <= '0;
        vv  <= '0;
        dot <= '0;
        ea  <= '0;
        eb  <= '0;
      end
      pmia_pkg::S_MUL: begin
        if (step < 5'd3) uu <= uu + 64'(prod);
        else if (step < 5'd6) vv <= vv + 64'(prod);
        else dot <= dot + prod;
      end
      pmia_pkg::S_NORM: begin
        if (uu[63:60] == 4'd0) begin
          uu <= uu << 2;
          ea <= ea + 5'd1;
        end
        if (vv[63:60] == 4'd0) begin
          vv <= vv << 2;
          eb <= eb + 5'd1;
        end
        sq_n   <= uu;
        sq_res <= '0;
      end
      pmia_pkg::S_SQRT: begin
        sq_n   <= sq_n_next;
        sq_res <= sq_res_next;
        if (step == 5'd0) begin
          case (root_sel)
            pmia_pkg::ROOT_U: begin
              su     <= sq_res_next[30:0];
              sq_n   <= vv;
              sq_res <= '0;
            end
            pmia_pkg::ROOT_V: sv <= sq_res_next[30:0];
            default: begin
              cx <= signed'({3'd0, cq});
              cy <= signed'(34'(sq_res_next));
              cz <= '0;
            end
          endcase
        end
      end
      pmia_pkg::S_DEN: den <= 64'(prod);
      pmia_pkg::S_SCALE: begin
        num <= scaled[63:0];
        if ((|scaled[127:64]) || scaled[63:0] >= den) cq <= pmia_pkg::ONE_Q30;
        else cq <= '0;
      end
      pmia_pkg::S_DIV: begin
        if (num2 >= den) begin
          num <= num2 - den;
          cq  <= {cq[29:0], 1'b1};
        end else begin
          num <= num2;
          cq  <= {cq[29:0], 1'b0};
        end
      end
      pmia_pkg::S_CSQ: begin
        sq_n   <= (64'd1 << 60) - 64'(prod);
        sq_res <= '0;
      end
      pmia_pkg::S_CORDIC: begin
        if (!cy[33]) begin
          cx <= cx + (cy >>> step);
          cy <= cy - (cx >>> step);
          cz <= cz + signed'({3'd0, pmia_pkg::atan_q30(step)});
        end else begin
          cx <= cx - (cy >>> step);
          cy <= cy + (cx >>> step);
          cz <= cz - signed'({3'd0, pmia_pkg::atan_q30(step)});
        end
      end
      pmia_pkg::S_NEXT: begin
        // Load the wrap-around corners.
        for (int k = 0; k < 3; k++) begin
          if (phase == pmia_pkg::PH_MID) begin
            pa[k] <= win[2][k]; pb[k] <= win[3][k]; pc[k] <= win[0][k];
          end else begin
            pa[k] <= win[3][k]; pb[k] <= win[0][k]; pc[k] <= win[1][k];
          end
        end
      end
      pmia_pkg::S_FINISH: begin
        if (out_load) begin
          if (vertex_count <= COUNT_BITS'(2)) begin
            result.max_angle      <= '0;
            result.degenerate     <= 1'b1;
            result.no_valid_angle <= 1'b0;
          end else begin
            result.max_angle      <= any_valid ? rm_ext[15:0] : 16'd0;
            result.degenerate     <= 1'b0;
            result.no_valid_angle <= !any_valid;
          end
        end
      end
      default: begin
        num <= num;
      end
    endcase
  end

endmodule

FILE: rtl/pmia_checker.sv
`include "assert_macros.svh"

module pmia_checker (
  input logic              clk,
  input logic              rst,
  input pmia_pkg::vertex_t vertex,
  input logic              vertex_valid,
  input logic              vertex_stall,
  input pmia_pkg::result_t result,
  input logic              result_valid,
  input logic              result_stall
);

  // Hold a stalled result.
  `ASSERT_NEXT(result_held, clk, rst, result_valid && result_stall, result_valid)
  // Never flag both special cases at once.
  `ASSERT_IMPLY(flags_exclusive, clk, rst, result_valid, !(result.degenerate && result.no_valid_angle))
  // Zero the angle on a degenerate polygon.
  `ASSERT_IMPLY(degen_zero, clk, rst, result_valid && result.degenerate, result.max_angle == 16'd0)
  // Close the polygon before taking the next vertex.
  `ASSERT_NEXT(last_busy, clk, rst, vertex_valid && !vertex_stall && vertex.last_vertex, vertex_stall)

endmodule

bind polygon_max_interior_angle pmia_checker u_pmia_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex       (vertex),
  .vertex_valid (vertex_valid),
  .vertex_stall (vertex_stall),
  .result       (result),
  .result_valid (result_valid),
  .result_stall (result_stall)
);
